// ===== hdl/pac_pkg.sv =====
// Shared widths, codes and control bundles for the polygon area and centroid block.
`timescale 1ns / 1ps
`default_nettype none
package pac_pkg;

    // Field and accumulator widths
    localparam int COORD_W  = 16;
    localparam int AREA_W   = 45;
    localparam int MOM_W    = 61;
    localparam int SUM_W    = 29;
    localparam int DEN_W    = AREA_W + 2;

    // Parameter defaults
    localparam int COORD_BITS_DEF   = 16;
    localparam int MAX_VERTICES_DEF = 4096;

    // Multiplier step codes
    localparam logic [1:0] STEP_PX  = 2'd0;
    localparam logic [1:0] STEP_CR  = 2'd1;
    localparam logic [1:0] STEP_MX  = 2'd2;
    localparam logic [1:0] STEP_MY  = 2'd3;

    // Division selector codes
    localparam logic [1:0] DSEL_CX  = 2'd0;
    localparam logic [1:0] DSEL_CY  = 2'd1;
    localparam logic [1:0] DSEL_MX  = 2'd2;
    localparam logic [1:0] DSEL_MY  = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       load_close;
        logic       step_en;
        logic [1:0] step;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic div_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== hdl/pac_in_if.sv =====
// Vertex input channel.
`timescale 1ns / 1ps
`default_nettype none
interface pac_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pac_pkg::COORD_W-1:0] vx;
    logic signed [pac_pkg::COORD_W-1:0] vy;
    logic                               ring_end;

    modport source (output valid, output vx, output vy, output ring_end, input ready);
    modport sink   (input valid, input vx, input vy, input ring_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/pac_out_if.sv =====
// Ring result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface pac_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pac_pkg::AREA_W-1:0]  double_area;
    logic signed [pac_pkg::COORD_W-1:0] centroid_x;
    logic signed [pac_pkg::COORD_W-1:0] centroid_y;
    logic signed [pac_pkg::COORD_W-1:0] mean_x;
    logic signed [pac_pkg::COORD_W-1:0] mean_y;
    logic                               area_valid;
    logic                               count_overflow;

    modport source (output valid, output double_area, output centroid_x, output centroid_y,
                    output mean_x, output mean_y, output area_valid, output count_overflow,
                    input ready);
    modport sink   (input valid, input double_area, input centroid_x, input centroid_y,
                    input mean_x, input mean_y, input area_valid, input count_overflow,
                    output ready);
endinterface
`default_nettype wire

// ===== hdl/pac_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module pac_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [pac_pkg::MOM_W-1:0]   dividend,
    input  wire logic signed [pac_pkg::DEN_W-1:0]   divisor,
    output logic                                    done,
    output logic signed [pac_pkg::MOM_W-1:0]        quotient
);
    localparam int NW  = pac_pkg::MOM_W;
    localparam int DW  = pac_pkg::DEN_W;
    localparam int CW  = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[NW-1] ^ divisor[DW-1];
            cnt_next  = '0;
            quo_next  = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
            den_next  = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (diff[DW+1] == 1'b0)
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule
`default_nettype wire

// ===== hdl/pac_dp.sv =====
// Datapath: ring state, shared multiplier, accumulators, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module pac_dp #(
    parameter int COORD_BITS   = pac_pkg::COORD_BITS_DEF,
    parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pac_pkg::cmd_t                        cmd,
    output pac_pkg::status_t                          status,
    input  wire logic [pac_pkg::COORD_W-1:0]          vx,
    input  wire logic [pac_pkg::COORD_W-1:0]          vy,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [pac_pkg::AREA_W-1:0]         out_area,
    output logic signed [pac_pkg::COORD_W-1:0]        out_cx,
    output logic signed [pac_pkg::COORD_W-1:0]        out_cy,
    output logic signed [pac_pkg::COORD_W-1:0]        out_mx,
    output logic signed [pac_pkg::COORD_W-1:0]        out_my,
    output logic                                      out_area_valid,
    output logic                                      out_ovf
);
    localparam int CB    = COORD_BITS;
    localparam int CRW   = 2 * CB + 1;
    localparam int PW    = 3 * CB + 2;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int AW    = pac_pkg::AREA_W;
    localparam int MW    = pac_pkg::MOM_W;
    localparam int SW    = pac_pkg::SUM_W;
    localparam int DW    = pac_pkg::DEN_W;
    localparam int OW    = pac_pkg::COORD_W;
    localparam logic signed [MW-1:0] C_HI = MW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [MW-1:0] C_LO = -C_HI - MW'(1);

    logic signed [CB-1:0] x, y;
    logic signed [CB-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic signed [2*CB-1:0] p_reg;
    logic signed [CRW-1:0]  cr_reg;
    logic signed [AW-1:0]   area_reg;
    logic signed [MW-1:0]   mom_x_reg, mom_y_reg;
    logic signed [SW-1:0]   sum_x_reg, sum_y_reg;
    logic signed [CB:0]     mul_a;
    logic signed [CRW-1:0]  mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [MW-1:0]   div_num;
    logic signed [DW-1:0]   div_den;
    logic                   div_done;
    logic signed [MW-1:0]   div_q;
    logic signed [CB-1:0]   q_clamp;
    logic signed [CB-1:0]   cx_reg, cy_reg, mx_reg, my_reg;
    logic                   valid_w;
    logic                   out_valid_reg, out_valid_next;
    logic signed [AW-1:0]   o_area_reg;
    logic signed [OW-1:0]   o_cx_reg, o_cy_reg, o_mx_reg, o_my_reg;
    logic                   o_av_reg, o_ovf_reg;

    // Take the low coordinate bits as a signed value
    assign x = $signed(vx[CB-1:0]);
    assign y = $signed(vy[CB-1:0]);

    // Shared multiplier operand select
    always_comb
    begin
        unique case (cmd.step)
            pac_pkg::STEP_PX:
            begin
                mul_a = (CB+1)'(ax_reg);
                mul_b = CRW'(by_reg);
            end
            pac_pkg::STEP_CR:
            begin
                mul_a = (CB+1)'(ay_reg);
                mul_b = CRW'(bx_reg);
            end
            pac_pkg::STEP_MX:
            begin
                mul_a = (CB+1)'(ax_reg) + (CB+1)'(bx_reg);
                mul_b = cr_reg;
            end
            default:
            begin
                mul_a = (CB+1)'(ay_reg) + (CB+1)'(by_reg);
                mul_b = cr_reg;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // Divider operand select
    always_comb
    begin
        unique case (cmd.div_sel)
            pac_pkg::DSEL_CX: div_num = mom_x_reg;
            pac_pkg::DSEL_CY: div_num = mom_y_reg;
            pac_pkg::DSEL_MX: div_num = MW'(sum_x_reg);
            default:          div_num = MW'(sum_y_reg);
        endcase
        if (cmd.div_sel == pac_pkg::DSEL_CX || cmd.div_sel == pac_pkg::DSEL_CY)
            div_den = (DW'(area_reg) <<< 1) + DW'(area_reg);
        else
            div_den = $signed({{(DW-CNT_W){1'b0}}, count_reg});
    end

    pac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Saturate a centroid quotient to the coordinate range
    always_comb
    begin
        priority if (div_q > C_HI)
            q_clamp = CB'(C_HI);
        else if (div_q < C_LO)
            q_clamp = CB'(C_LO);
        else
            q_clamp = div_q[CB-1:0];
    end

    assign valid_w = (count_reg >= CNT_W'(3)) && (area_reg != '0);

    // Ring state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            area_reg    <= '0;
            mom_x_reg   <= '0;
            mom_y_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            area_reg    <= '0;
            mom_x_reg   <= '0;
            mom_y_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (count_reg == CNT_W'(MAX_VERTICES))
                    ovf_reg <= 1'b1;
                else
                begin
                    if (count_reg == '0)
                    begin
                        first_x_reg <= x;
                        first_y_reg <= y;
                    end
                    prev_x_reg <= x;
                    prev_y_reg <= y;
                    sum_x_reg  <= sum_x_reg + SW'(x);
                    sum_y_reg  <= sum_y_reg + SW'(y);
                    count_reg  <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.step_en && cmd.step == pac_pkg::STEP_MX)
            begin
                area_reg  <= area_reg + AW'(cr_reg);
                mom_x_reg <= mom_x_reg + MW'(prod);
            end
            if (cmd.step_en && cmd.step == pac_pkg::STEP_MY)
                mom_y_reg <= mom_y_reg + MW'(prod);
        end
    end

    // Edge operands, partial products and quotients
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= x;
            by_reg <= y;
        end
        else if (cmd.load_close)
        begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= first_x_reg;
            by_reg <= first_y_reg;
        end
        if (cmd.step_en && cmd.step == pac_pkg::STEP_PX)
            p_reg <= prod[2*CB-1:0];
        if (cmd.step_en && cmd.step == pac_pkg::STEP_CR)
            cr_reg <= CRW'(p_reg) - CRW'($signed(prod[2*CB-1:0]));
        if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                pac_pkg::DSEL_CX: cx_reg <= q_clamp;
                pac_pkg::DSEL_CY: cy_reg <= q_clamp;
                pac_pkg::DSEL_MX: mx_reg <= div_q[CB-1:0];
                default:          my_reg <= div_q[CB-1:0];
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_area_reg <= valid_w ? area_reg : '0;
            o_cx_reg   <= valid_w ? OW'(cx_reg) : '0;
            o_cy_reg   <= valid_w ? OW'(cy_reg) : '0;
            o_mx_reg   <= OW'(mx_reg);
            o_my_reg   <= OW'(my_reg);
            o_av_reg   <= valid_w;
            o_ovf_reg  <= ovf_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CNT_W'(MAX_VERTICES));
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_area       = o_area_reg;
    assign out_cx         = o_cx_reg;
    assign out_cy         = o_cy_reg;
    assign out_mx         = o_mx_reg;
    assign out_my         = o_my_reg;
    assign out_area_valid = o_av_reg;
    assign out_ovf        = o_ovf_reg;
endmodule
`default_nettype wire

// ===== hdl/pac_ctrl.sv =====
// Controller: sequences vertex intake, edge steps, divisions and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pac_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_ready,
    input  wire pac_pkg::status_t  status,
    output pac_pkg::cmd_t          cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_E0     = 4'd1;
    localparam logic [3:0] S_E1     = 4'd2;
    localparam logic [3:0] S_E2     = 4'd3;
    localparam logic [3:0] S_E3     = 4'd4;
    localparam logic [3:0] S_CLOSE  = 4'd5;
    localparam logic [3:0] S_DSTART = 4'd6;
    localparam logic [3:0] S_DWAIT  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       close_reg, close_next;
    logic [1:0] dsel_reg, dsel_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        close_next = close_reg;
        dsel_next  = dsel_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.div_sel = dsel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = in_last;
                    close_next = 1'b0;
                    // No edge for the first vertex or a dropped one
                    if (status.count_zero || status.count_full)
                        state_next = in_last ? S_CLOSE : S_IDLE;
                    else
                        state_next = S_E0;
                end
            end
            S_E0:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = pac_pkg::STEP_PX;
                state_next  = S_E1;
            end
            S_E1:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = pac_pkg::STEP_CR;
                state_next  = S_E2;
            end
            S_E2:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = pac_pkg::STEP_MX;
                state_next  = S_E3;
            end
            S_E3:
            begin
                cmd.step_en = 1'b1;
                cmd.step    = pac_pkg::STEP_MY;
                priority if (close_reg)
                begin
                    dsel_next  = pac_pkg::DSEL_CX;
                    state_next = S_DSTART;
                end
                else if (last_reg)
                    state_next = S_CLOSE;
                else
                    state_next = S_IDLE;
            end
            S_CLOSE:
            begin
                cmd.load_close = 1'b1;
                close_next     = 1'b1;
                state_next     = S_E0;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (dsel_reg == pac_pkg::DSEL_MY)
                        state_next = S_EMIT;
                    else
                    begin
                        dsel_next  = dsel_reg + 2'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    close_next = 1'b0;
                    last_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            close_reg <= 1'b0;
            dsel_reg  <= pac_pkg::DSEL_CX;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            close_reg <= close_next;
            dsel_reg  <= dsel_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/polygon_area_centroid.sv =====
// Top level of the shoelace polygon area and centroid block.
//
//   channel  dir  word
//   vtx      in   vx, vy, ring_end       one ring vertex
//   res      out  double_area, centroid, mean, area_valid, count_overflow
//
// A vertex that opens the ring or is dropped takes only the intake; any other
// vertex also takes four passes through the one shared multiplier.
// The last vertex adds the closing edge and four divisions of 61 quotient bits
// each before the ring's result is loaded.
// Reset clears all ring state; there is no clearing pass.
// A result waits in the output register; a stalled result delays only the next ring end.
`timescale 1ns / 1ps
`default_nettype none
module polygon_area_centroid #(
    parameter int COORD_BITS   = pac_pkg::COORD_BITS_DEF,
    parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pac_in_if.sink     vtx,
    pac_out_if.source  res
);
    pac_pkg::cmd_t    cmd;
    pac_pkg::status_t status;

    pac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vtx.valid),
        .in_last  (vtx.ring_end),
        .in_ready (vtx.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pac_dp #(
        .COORD_BITS   (COORD_BITS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .vx             (vtx.vx),
        .vy             (vtx.vy),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_area       (res.double_area),
        .out_cx         (res.centroid_x),
        .out_cy         (res.centroid_y),
        .out_mx         (res.mean_x),
        .out_my         (res.mean_y),
        .out_area_valid (res.area_valid),
        .out_ovf        (res.count_overflow)
    );

`ifndef NO_ASSERTIONS
    // Never load a result over one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over a pending word");

    // Vertices are taken only in cycles with no division start and no edge step
    a_no_div_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        vtx.ready |-> !cmd.div_start && !cmd.step_en)
        else $error("vertex intake overlaps datapath work");

    // A valid area is nonzero, an invalid one reports zero centroid
    a_area_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.area_valid == (res.double_area != '0)))
        else $error("area_valid disagrees with double_area");

    a_zero_centroid: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.area_valid |-> res.centroid_x == '0 && res.centroid_y == '0)
        else $error("nonzero centroid without valid area");
`endif
endmodule
`default_nettype wire

// ===== tb/pac_tb_pkg.sv =====
// Testbench timing constants: receiver hold length and end-of-run settle time.
`timescale 1ns / 1ps
package pac_tb_pkg;
    localparam int CHECK_LATENCY = 400;
    localparam int HOLD_CYCLES   = 2000;
endpackage

// ===== tb/testbench.sv =====
// Self-checking testbench for the polygon area and centroid block.
`timescale 1ns / 1ps
module testbench;
    localparam int MAX_VTX   = pac_pkg::MAX_VERTICES_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int AW        = pac_pkg::AREA_W;
    localparam int CW        = pac_pkg::COORD_W;

    typedef struct packed {
        logic signed [AW-1:0] area;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] mx;
        logic signed [CW-1:0] my;
        logic                 valid;
        logic                 ovf;
    } ring_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    pac_in_if  vtx_if ();
    pac_out_if res_if ();

    polygon_area_centroid u_top (.clk(clk), .rst_n(rst_n), .vtx(vtx_if), .res(res_if));

    always #4 clk = ~clk;

    // Ring state of the predictor
    longint first_x, first_y, prev_x, prev_y;
    int     vcount;
    longint area_acc, momx_acc, momy_acc, sumx_acc, sumy_acc;
    bit     ovf_seen;
    ring_result_t result_q[$];

    int  errors = 0;
    int  rings_sent = 0;
    int  words_sent = 0;
    int  results_seen = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    function automatic void clear_ring();
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; vcount = 0;
        area_acc = 0; momx_acc = 0; momy_acc = 0; sumx_acc = 0; sumy_acc = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic void add_edge(longint ax, longint ay, longint bx, longint by);
        longint cr;
        cr = ax * by - ay * bx;
        area_acc += cr;
        momx_acc += (ax + bx) * cr;
        momy_acc += (ay + by) * cr;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Advance the predictor by one vertex; queue a result on the ring end
    function automatic void predict_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                           logic last);
        ring_result_t r;
        longint d;
        if (vcount >= MAX_VTX)
            ovf_seen = 1'b1;
        else
        begin
            if (vcount == 0)
            begin
                first_x = x; first_y = y;
            end
            else
                add_edge(prev_x, prev_y, x, y);
            prev_x = x; prev_y = y;
            sumx_acc += x; sumy_acc += y;
            vcount++;
        end
        if (!last)
            return;
        add_edge(prev_x, prev_y, first_x, first_y);
        r = '0;
        r.valid = (vcount >= 3) && (area_acc != 0);
        if (r.valid)
        begin
            d = 3 * area_acc;
            r.area = AW'(area_acc);
            r.cx = CW'(clamp16(momx_acc / d));
            r.cy = CW'(clamp16(momy_acc / d));
        end
        if (vcount != 0)
        begin
            r.mx = CW'(sumx_acc / vcount);
            r.my = CW'(sumy_acc / vcount);
        end
        r.ovf = ovf_seen;
        result_q = {result_q, r};
        clear_ring();
    endfunction

    // Send one word, with random idle bursts ahead of it; valid stays up afterwards
    task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
        int gap;
        if (idle_on && ($urandom_range(0, 3) == 0))
        begin
            gap = $urandom_range(1, 6);
            vtx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_if.valid    <= 1'b1;
        vtx_if.vx       <= x;
        vtx_if.vy       <= y;
        vtx_if.ring_end <= last;
        @(posedge clk);
        while (!vtx_if.ready)
            @(posedge clk);
        predict_vertex(x, y, last);
        words_sent++;
        if (last)
            rings_sent++;
    endtask

    // Drop valid once the sender has nothing more to offer
    task automatic stop_input();
        vtx_if.valid <= 1'b0;
    endtask

    task automatic drain_results();
        stop_input();
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus a long counted hold on request
    initial
    begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (pac_tb_pkg::HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && ($urandom_range(0, 3) == 0))
            begin
                gap = $urandom_range(1, 6);
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        ring_result_t e;
        ring_result_t a;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            a = {res_if.double_area, res_if.centroid_x, res_if.centroid_y, res_if.mean_x,
                 res_if.mean_y, res_if.area_valid, res_if.count_overflow};
            results_seen++;
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %h", $time, a);
            end
            else
            begin
                e = result_q.pop_front();
                if (a.area !== e.area)
                    $display("%0t: double_area exp %0d got %0d", $time, e.area, a.area);
                if (a.cx !== e.cx)
                    $display("%0t: centroid_x exp %0d got %0d", $time, e.cx, a.cx);
                if (a.cy !== e.cy)
                    $display("%0t: centroid_y exp %0d got %0d", $time, e.cy, a.cy);
                if (a.mx !== e.mx)
                    $display("%0t: mean_x exp %0d got %0d", $time, e.mx, a.mx);
                if (a.my !== e.my)
                    $display("%0t: mean_y exp %0d got %0d", $time, e.my, a.my);
                if (a.valid !== e.valid)
                    $display("%0t: area_valid exp %0b got %0b", $time, e.valid, a.valid);
                if (a.ovf !== e.ovf)
                    $display("%0t: count_overflow exp %0b got %0b", $time, e.ovf, a.ovf);
                if (a !== e)
                    errors++;
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX)
        begin
            $display("watchdog expired at %0t", $time);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_ring(int n);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(), rand_coord(), i == n - 1);
    endtask

    // Field extremes and the special rings
    task automatic test_directed();
        send_vertex(16'sd5, -16'sd7, 1'b1);                 // single vertex ring
        send_vertex(16'sd1, 16'sd1, 1'b0);                  // two vertices
        send_vertex(-16'sd3, 16'sd4, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);                  // ccw square
        send_vertex(16'sd100, 16'sd0, 1'b0);
        send_vertex(16'sd100, 16'sd100, 1'b0);
        send_vertex(16'sd0, 16'sd100, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);            // full-range cw triangle, closed
        send_vertex(16'sh8000, 16'sh7FFF, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vertex(16'sh8000, 16'sh8000, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);                  // collinear, zero area
        send_vertex(16'sd2, 16'sd2, 1'b0);
        send_vertex(16'sd4, 16'sd4, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);                  // bow tie, area cancels
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd10, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);                  // self-crossing, centroid far out
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFE, 1'b0);
        send_vertex(16'sh8000, 16'sh8000, 1'b1);
        drain_results();
    endtask

    // Ring past the vertex limit, last three words dropped
    task automatic test_overflow();
        send_ring(MAX_VTX + 3);
        drain_results();
    endtask

    task automatic test_random(int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words)
            send_ring(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 12));
        drain_results();
    endtask

    // Hold the receiver while rings keep coming, then pause the sender
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_ring(4);
        send_ring(3);
        send_ring(3);
        send_ring(3);
        drain_results();
        repeat (300) @(posedge clk);
        send_ring(5);
        drain_results();
    endtask

    initial
    begin
        vtx_if.valid <= 1'b0;
        vtx_if.vx <= '0;
        vtx_if.vy <= '0;
        vtx_if.ring_end <= 1'b0;
        clear_ring();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random(500);
        test_backpressure();
        idle_on = 1'b0;
        test_random(200);
        repeat (pac_tb_pkg::CHECK_LATENCY) @(posedge clk);
        $display("covered %0d rings in %0d words, %0d results checked", rings_sent,
                 words_sent, results_seen);
        $display("incl. short, degenerate, self-crossing, overflow and stalled rings");
        if (errors == 0 && result_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
